### hdl/ssms_pkg.sv
// Shared types and constants for the stock span stack block.
`default_nettype none
package ssms_pkg;

    localparam int HEIGHT_W = 16;
    localparam int SPAN_W   = 11;
    localparam logic [SPAN_W-1:0] SPAN_FIELD_MAX = 11'd2047;

    // Front-end classification carried with every queued item.
    typedef struct packed {
        logic start;  // first bar of a new sequence
        logic ovf;    // bar lies beyond the sequence limit
    } t_class;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic busy;
        logic pop;
        logic push;
        logic empty;
    } t_back_stat;

endpackage
`default_nettype wire

### hdl/ssms_if.sv
// Valid/ready channel interfaces for bar items and span results.
`default_nettype none
interface ssms_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssms_pkg::HEIGHT_W-1:0] height;
    logic                                 start_req;

    modport source (output valid, output height, output start_req, input ready);
    modport sink   (input valid, input height, input start_req, output ready);
endinterface

interface ssms_out_if;
    logic                        valid;
    logic                        ready;
    logic [ssms_pkg::SPAN_W-1:0] span;
    logic                        overflow;

    modport source (output valid, output span, output overflow, input ready);
    modport sink   (input valid, input span, input overflow, output ready);
endinterface
`default_nettype wire

### hdl/stock_span_monotonic_stack_top.sv
// Top level of the stock span block: front queue, stack engine, checks.
// The stack engine works on one item at a time and takes no new one until done:
// dequeue, then one compare per pop plus a final compare/push, which waits
//   while the result register is still held by the output.
// The stack RAM port and the single compare loop set that pace.
// Reset: synchronous active low; clears queue, position, engine state, stack
//   depth and output valid. Stack RAM is not cleared; depth guards reads.
`default_nettype none
module stock_span_monotonic_stack_top #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssms_in_if.sink    i_in,
    ssms_out_if.source o_out
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [ssms_pkg::SPAN_W-1:0] OVF_SPAN =
        (MAX_LEN > 2047) ? ssms_pkg::SPAN_FIELD_MAX : ssms_pkg::SPAN_W'(MAX_LEN);

    // queue between front and back
    logic                                 q_valid;
    logic                                 q_ready;
    logic signed [ssms_pkg::HEIGHT_W-1:0] q_height;
    ssms_pkg::t_class                     q_cls;
    logic [CW-1:0]                        q_pos;
    ssms_pkg::t_back_stat                 stat;

    // front: takes bars, tags position and overflow class
    ssms_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_height (q_height),
        .o_q_cls    (q_cls),
        .o_q_pos    (q_pos)
    );

    // back: pops lower-or-equal entries, pushes the bar, emits the span
    ssms_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_height (q_height),
        .i_q_cls    (q_cls),
        .i_q_pos    (q_pos),
        .o_out      (o_out),
        .o_stat     (stat)
    );

    // an overflowed bar always reports the saturated span
    a_ovf_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.span == OVF_SPAN)
        else $error("overflow result with wrong span");

    // a span is never zero
    a_span_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.span != '0)
        else $error("zero span");

    // never pop an empty stack, and never pop and push in one cycle
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pop |-> !stat.empty && !stat.push)
        else $error("pop on empty stack or with push");

    // the engine takes a queued item only when it is free
    a_deq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_ready |=> stat.busy)
        else $error("dequeued item not processed");

    // nothing is presented right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

### hdl/ssms_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module ssms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hdl/ssms_front.sv
// Front end: accepts bars, assigns positions, flags overflow, queues items.
`default_nettype none
module ssms_front #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    ssms_in_if.sink                                   i_in,
    output      logic                                 o_q_valid,
    input  wire logic                                 i_q_ready,
    output      logic signed [ssms_pkg::HEIGHT_W-1:0] o_q_height,
    output      ssms_pkg::t_class                     o_q_cls,
    output      logic [$clog2(MAX_LEN+1)-1:0]         o_q_pos
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic signed [ssms_pkg::HEIGHT_W-1:0] r_q_h   [2];
    ssms_pkg::t_class                     r_q_cls [2];
    logic [CW-1:0]                        r_q_pos [2];
    logic                                 r_wp;
    logic                                 r_rp;
    logic [1:0]                           r_cnt;
    logic [CW-1:0]                        r_pos;

    logic          enq;
    logic          deq;
    logic [CW-1:0] item_pos;
    logic          item_ovf;

    assign i_in.ready = (r_cnt != 2'd2);
    assign enq        = i_in.valid && i_in.ready;
    assign deq        = o_q_valid && i_q_ready;

    // position restarts at a start marker; sticks at the limit
    assign item_pos = i_in.start_req ? '0 : r_pos;
    assign item_ovf = (item_pos == CW'(MAX_LEN));

    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_height = r_q_h[r_rp];
    assign o_q_cls    = r_q_cls[r_rp];
    assign o_q_pos    = r_q_pos[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_pos <= '0;
        end else begin
            if (enq) begin
                r_q_h[r_wp]         <= i_in.height;
                r_q_cls[r_wp].start <= i_in.start_req;
                r_q_cls[r_wp].ovf   <= item_ovf;
                r_q_pos[r_wp]       <= item_pos;
                r_wp                <= ~r_wp;
                r_pos               <= item_ovf ? item_pos : item_pos + CW'(1);
            end
            if (deq) begin
                r_rp <= ~r_rp;
            end
            case ({enq, deq})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/ssms_back.sv
// Back end: monotonic stack pop/push engine and result register.
`default_nettype none
module ssms_back #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_valid,
    output      logic                                 o_q_ready,
    input  wire logic signed [ssms_pkg::HEIGHT_W-1:0] i_q_height,
    input  wire ssms_pkg::t_class                     i_q_cls,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]         i_q_pos,
    ssms_out_if.source                                o_out,
    output      ssms_pkg::t_back_stat                 o_stat
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int HW = ssms_pkg::HEIGHT_W;
    localparam int SW = (CW > ssms_pkg::SPAN_W) ? CW : ssms_pkg::SPAN_W;
    localparam int EW = HW + AW;
    localparam logic [ssms_pkg::SPAN_W-1:0] OVF_SPAN =
        (MAX_LEN > 2047) ? ssms_pkg::SPAN_FIELD_MAX : ssms_pkg::SPAN_W'(MAX_LEN);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CMP  = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic signed [HW-1:0] r_h;
    ssms_pkg::t_class     r_cls;
    logic [CW-1:0]        r_pos;
    logic signed [HW-1:0] r_top_h;
    logic [AW-1:0]        r_top_p;
    logic                 r_from_ram;
    logic                 r_out_valid;
    logic [ssms_pkg::SPAN_W-1:0] r_out_span;
    logic                 r_out_ovf;

    logic [EW-1:0]        rd_data;
    logic [CW-1:0]        count_m2;
    logic signed [HW-1:0] cur_top_h;
    logic [AW-1:0]        cur_top_p;
    logic                 out_free;
    logic                 do_pop;
    logic                 do_fin;
    logic                 do_push;
    logic [CW-1:0]        span_raw;
    logic [SW-1:0]        span_ext;
    logic [ssms_pkg::SPAN_W-1:0] span_sat;

    // entry below the top is always being fetched, ready right after a pop
    assign count_m2 = r_count - CW'(2);

    ssms_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_h, r_pos[AW-1:0]}),
        .i_raddr (count_m2[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign cur_top_h = r_from_ram ? $signed(rd_data[EW-1:AW]) : r_top_h;
    assign cur_top_p = r_from_ram ? rd_data[AW-1:0] : r_top_p;

    assign out_free = !r_out_valid || o_out.ready;
    assign do_pop   = (r_state == ST_CMP) && !r_cls.ovf && (r_count != '0) &&
                      (cur_top_h <= r_h);
    assign do_fin   = (r_state == ST_CMP) && !do_pop && out_free;
    assign do_push  = do_fin && !r_cls.ovf && (r_count < CW'(MAX_LEN));

    assign span_raw = (r_count == '0) ? r_pos + CW'(1) : r_pos - CW'(cur_top_p);
    assign span_ext = SW'(span_raw);
    assign span_sat = (span_ext > SW'(ssms_pkg::SPAN_FIELD_MAX)) ?
                      ssms_pkg::SPAN_FIELD_MAX : span_ext[ssms_pkg::SPAN_W-1:0];

    assign o_q_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_CMP;
                    if (i_q_cls.start) begin
                        n_count = '0;
                    end
                end
            end
            ST_CMP: begin
                if (do_pop) begin
                    n_count = r_count - CW'(1);
                end else if (do_fin) begin
                    n_state = ST_IDLE;
                    if (do_push) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_from_ram  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_IDLE) begin
                if (i_q_valid) begin
                    r_h   <= i_q_height;
                    r_cls <= i_q_cls;
                    r_pos <= i_q_pos;
                end
                r_from_ram <= 1'b0;
            end else begin
                r_top_h    <= cur_top_h;
                r_top_p    <= cur_top_p;
                r_from_ram <= do_pop;
                if (do_push) begin
                    r_top_h <= r_h;
                    r_top_p <= r_pos[AW-1:0];
                end
            end
            if (do_fin) begin
                r_out_valid <= 1'b1;
                r_out_span  <= r_cls.ovf ? OVF_SPAN : span_sat;
                r_out_ovf   <= r_cls.ovf;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.span     = r_out_span;
    assign o_out.overflow = r_out_ovf;

    assign o_stat.busy  = (r_state == ST_CMP);
    assign o_stat.pop   = do_pop;
    assign o_stat.push  = do_push;
    assign o_stat.empty = (r_count == '0);

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the stock span monotonic stack block.
`default_nettype none
module tb;

    localparam int MAX_BARS    = 1024;
    localparam int POS_W       = $clog2(MAX_BARS);
    localparam int RANDOM_BARS = 1850;
    localparam int QUIET_LIMIT = 6000;  // watchdog limit, above the longest legal quiet stretch
    localparam int SETTLE_CYC  = 20;

    typedef enum int {RDY_OPEN, RDY_COIN, RDY_BURSTY} t_rdy_mode;
    typedef enum int {HT_ANY, HT_NARROW, HT_RISE, HT_FALL, HT_WALK} t_height_style;

    // One directed bar; pin marks rows whose answer is written out by hand.
    typedef struct packed {
        logic signed [ssms_pkg::HEIGHT_W-1:0] height;
        logic                                 start;
        logic                                 pin;
        logic [ssms_pkg::SPAN_W-1:0]          span;
        logic                                 ovf;
    } t_bar_row;

    typedef struct packed {
        logic [ssms_pkg::SPAN_W-1:0] span;
        logic                        ovf;
    } t_span_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssms_in_if  bar_if ();
    ssms_out_if span_if ();

    stock_span_monotonic_stack_top #(.MAX_LEN(MAX_BARS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bar_if.sink),
        .o_out   (span_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Directed bars: reset without marker, extremes, equal heights, ramps.
    t_bar_row dir_rows [21] = '{
        '{16'sh0000, 1'b0, 1'b1, 11'd1, 1'b0},  // first bar after reset, no marker
        '{16'sh8000, 1'b0, 1'b1, 11'd1, 1'b0},
        '{16'sh8000, 1'b0, 1'b1, 11'd2, 1'b0},  // equal height does not stop span
        '{16'sh7FFF, 1'b0, 1'b1, 11'd4, 1'b0},  // pops everything
        '{16'sh7FFF, 1'b1, 1'b1, 11'd1, 1'b0},  // new sequence
        '{16'sh7FFF, 1'b0, 1'b1, 11'd2, 1'b0},
        '{16'shFFFF, 1'b0, 1'b1, 11'd1, 1'b0},
        '{16'sh5555, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'shAAAA, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh5555, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh0001, 1'b1, 1'b1, 11'd1, 1'b0},
        '{16'sh0002, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh0003, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh0004, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh0003, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh0002, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh0005, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'sh8000, 1'b1, 1'b1, 11'd1, 1'b0},
        '{16'sh8000, 1'b0, 1'b1, 11'd2, 1'b0},
        '{16'sh8000, 1'b0, 1'b1, 11'd3, 1'b0},
        '{16'sh0000, 1'b1, 1'b1, 11'd1, 1'b0}
    };

    // Span predictor state.
    logic signed [ssms_pkg::HEIGHT_W-1:0] stk_height [MAX_BARS];
    logic [POS_W-1:0]                     stk_pos    [MAX_BARS];
    int unsigned                          stk_depth  = 0;
    int unsigned                          next_pos   = 0;
    int unsigned                          deepest    = 0;
    int unsigned                          widest     = 0;

    t_span_res span_q [$];

    // Hand-written answer travels with the item it belongs to.
    logic                        pinned_on;
    logic [ssms_pkg::SPAN_W-1:0] pinned_span;
    logic                        pinned_ovf;

    int mismatches   = 0;
    int results_seen = 0;
    int ovf_seen     = 0;
    int bars_sent    = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;

    function automatic logic [ssms_pkg::SPAN_W-1:0] sat_span(input int unsigned s);
        return (s > ssms_pkg::SPAN_FIELD_MAX) ? ssms_pkg::SPAN_FIELD_MAX
                                              : s[ssms_pkg::SPAN_W-1:0];
    endfunction

    function automatic t_span_res predict_span(
        input logic signed [ssms_pkg::HEIGHT_W-1:0] h, input logic st);
        t_span_res   r;
        int unsigned s;
        if (st) begin
            stk_depth = 0;
            next_pos  = 0;
        end
        if (next_pos >= MAX_BARS) begin
            // sequence too long: saturate, state frozen until next marker
            r.span = sat_span(MAX_BARS);
            r.ovf  = 1'b1;
            return r;
        end
        while (stk_depth > 0 && stk_height[stk_depth-1] <= h)
            stk_depth--;
        s = (stk_depth == 0) ? next_pos + 1 : next_pos - stk_pos[stk_depth-1];
        if (stk_depth < MAX_BARS) begin
            stk_height[stk_depth] = h;
            stk_pos[stk_depth]    = next_pos[POS_W-1:0];
            stk_depth++;
        end
        next_pos++;
        if (stk_depth > deepest) deepest = stk_depth;
        if (s > widest) widest = s;
        r.span = sat_span(s);
        r.ovf  = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t, result %0d: %s got %0d expected %0d",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // Scoreboard: retire results first, then record newly accepted bars.
    always @(posedge i_clk) begin
        t_span_res want;
        t_span_res guess;
        t_span_res pinned;
        if (i_rst_n) begin
            if (span_if.valid && span_if.ready) begin
                results_seen++;
                if (span_if.overflow) ovf_seen++;
                if (span_q.size() == 0) begin
                    report_mismatch("result with no bar pending, span", span_if.span, -1);
                end else begin
                    want = span_q[0];
                    span_q.delete(0);
                    if (span_if.span !== want.span)
                        report_mismatch("span", span_if.span, want.span);
                    if (span_if.overflow !== want.ovf)
                        report_mismatch("overflow", span_if.overflow, want.ovf);
                end
            end
            if (bar_if.valid && bar_if.ready) begin
                guess = predict_span(bar_if.height, bar_if.start_req);
                if (pinned_on) begin
                    pinned.span = pinned_span;
                    pinned.ovf  = pinned_ovf;
                    span_q.insert(span_q.size(), pinned);
                end else begin
                    span_q.insert(span_q.size(), guess);
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (bar_if.valid && bar_if.ready) || (span_if.valid && span_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles, %0d results pending",
                     quiet_cycles, span_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure: wide open, coin flips, or stall bursts.
    initial begin
        t_rdy_mode mode;
        int        mode_left;
        int        stall_left;
        mode       = RDY_OPEN;
        mode_left  = 0;
        stall_left = 0;
        span_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_rdy_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                RDY_OPEN: begin
                    span_if.ready <= 1'b1;
                end
                RDY_COIN: begin
                    span_if.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if (stall_left > 0) begin
                        span_if.ready <= 1'b0;
                        stall_left--;
                    end else begin
                        span_if.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    // Offer one bar and hold it until taken; bursts separated by gaps.
    task automatic send_bar(input logic signed [ssms_pkg::HEIGHT_W-1:0] h,
                            input logic st, input logic pin = 1'b0,
                            input logic [ssms_pkg::SPAN_W-1:0] pspan = '0,
                            input logic povf = 1'b0);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            bar_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        bar_if.valid     <= 1'b1;
        bar_if.height    <= h;
        bar_if.start_req <= st;
        pinned_on        <= pin;
        pinned_span      <= pspan;
        pinned_ovf       <= povf;
        do @(posedge i_clk); while (!bar_if.ready);
        burst_left--;
        bars_sent++;
    endtask

    // Stop offering bars until every pending span is back.
    task automatic drain_spans();
        bar_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (span_q.size() != 0) @(posedge i_clk);
    endtask

    // One random sequence; fresh=0 makes it continue the previous one.
    task automatic send_run(input int len, input logic fresh);
        t_height_style style;
        int            walk;
        logic signed [ssms_pkg::HEIGHT_W-1:0] h;
        style = t_height_style'($urandom_range(0, 4));
        walk  = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < len; i++) begin
            case (style)
                HT_ANY:    walk = int'($urandom_range(0, 65535)) - 32768;
                HT_NARROW: walk = int'($urandom_range(0, 8)) - 4;   // many equal heights
                HT_RISE:   walk = walk + int'($urandom_range(0, 300));
                HT_FALL:   walk = walk - int'($urandom_range(0, 300));
                default:   walk = walk + int'($urandom_range(0, 400)) - 200;
            endcase
            if (walk > 32767)  walk = 32767;
            if (walk < -32768) walk = -32768;
            h = walk[ssms_pkg::HEIGHT_W-1:0];
            send_bar(h, fresh && (i == 0));
        end
    endtask

    task automatic send_runs_until(input int total);
        int len;
        while (bars_sent < total) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
            send_run(len, $urandom_range(0, 7) != 0);
        end
    endtask

    initial begin
        logic signed [ssms_pkg::HEIGHT_W-1:0] h;
        i_rst_n          <= 1'b0;
        bar_if.valid     <= 1'b0;
        bar_if.height    <= '0;
        bar_if.start_req <= 1'b0;
        pinned_on        <= 1'b0;
        pinned_span      <= '0;
        pinned_ovf       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_bar(dir_rows[k].height, dir_rows[k].start, dir_rows[k].pin,
                     dir_rows[k].span, dir_rows[k].ovf);

        send_runs_until(420);
        drain_spans();

        // Full-length sequence: strictly falling bars fill all but one stack entry, then the
        // tallest bar pops all of it for the widest span, then the limit trips.
        h = 16'sd32000;
        send_bar(h, 1'b1);
        for (int i = 1; i < MAX_BARS - 1; i++) begin
            h = h - ssms_pkg::HEIGHT_W'($urandom_range(1, 63));
            send_bar(h, 1'b0);
        end
        send_bar(16'sh7FFF, 1'b0);
        repeat (6) send_bar(ssms_pkg::HEIGHT_W'($urandom_range(0, 65535)), 1'b0);
        send_bar(ssms_pkg::HEIGHT_W'($urandom_range(0, 65535)), 1'b1);

        send_runs_until(RANDOM_BARS);
        drain_spans();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Covered %0d bars and %0d spans: %0d saturated past the length limit,",
                 bars_sent, results_seen, ovf_seen);
        $display("widest span %0d, deepest stack %0d entries.", widest, deepest);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
